>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ofs_pkg.sv
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared types, codes and helpers of the overlapped frame splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofs_pkg;

	// Command codes of the func field.
	localparam logic [1:0] FUNC_PUSH  = 2'd0;
	localparam logic [1:0] FUNC_PULL  = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FRAME_LEN = 2'd0;
	localparam logic [1:0] CFG_HOP       = 2'd1;
	localparam logic [1:0] CFG_ROUND     = 2'd2;

	localparam int LEN_BITS   = 10;
	localparam int PLEN_BITS  = 11;
	localparam int CFG_BITS   = 10;
	localparam int FRAME_LEN_RST = 512;
	localparam int HOP_RST       = 256;

	// Per-item control carried alongside the memory read.
	typedef struct packed {
		logic out_valid;
		logic use_mem;
		logic last;
		logic flush;
		logic dropped;
	} res_ctl_t;

	// Smallest power of two at or above v; a length of zero gives one.
	function automatic logic [PLEN_BITS-1:0] ceil_pow2(input logic [LEN_BITS-1:0] v);
		logic [LEN_BITS-1:0] m;
		m = v - LEN_BITS'(1);
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		if (v <= LEN_BITS'(1)) begin
			return PLEN_BITS'(1);
		end
		return {1'b0, m} + PLEN_BITS'(1);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/ofs_ram.sv
// ----------------------------------------------------------------------------
// ofs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ofs_ctrl.sv
// ----------------------------------------------------------------------------
// ofs_ctrl
// Configuration registers, ring pointers and frame sequencing; drives the
// sample store and holds the first pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofs_ctrl #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_FRAME   = 512,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [ofs_pkg::CFG_BITS-1:0]          cfg_data,
	input  wire logic                                  accept,
	input  wire logic [1:0]                            func,
	input  wire logic [SAMPLE_BITS-1:0]                sample_in,
	input  wire logic                                  take_s1,
	output logic                                       valid_s1,
	output ofs_pkg::res_ctl_t                          ctl_s1,
	output logic [$clog2(STORE_DEPTH+1)-1:0]           buffered_s1,
	output logic                                       ram_we,
	output logic [$clog2(STORE_DEPTH)-1:0]             ram_waddr,
	output logic [SAMPLE_BITS-1:0]                     ram_wdata,
	output logic                                       ram_re,
	output logic [$clog2(STORE_DEPTH)-1:0]             ram_raddr
);

	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int FILL_W  = $clog2(STORE_DEPTH + 1);
	localparam int LEN_MAX = (MAX_FRAME < 1023) ? MAX_FRAME : 1023;
	localparam int POS_W   = $clog2(LEN_MAX);
	localparam int SW      = ((FILL_W > ofs_pkg::PLEN_BITS) ? FILL_W : ofs_pkg::PLEN_BITS) + 1;
	localparam int LEN_RST = (ofs_pkg::FRAME_LEN_RST > LEN_MAX) ? LEN_MAX : ofs_pkg::FRAME_LEN_RST;
	localparam int LB      = ofs_pkg::LEN_BITS;
	localparam int PB      = ofs_pkg::PLEN_BITS;

	logic [LB-1:0]     len_q, hop_q, len_nx, len_wr;
	logic              round_q, round_nx;
	logic [PB-1:0]     plen_q, plen_nx;

	logic [AW-1:0]     head_q, head_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              flush_q, flush_n;

	logic [SW-1:0]     fill_x, len_x, hop_x, plen_x, drop_x, rpos, p0;
	logic              ready;
	ofs_pkg::res_ctl_t ctl_n;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
		logic [SW-1:0] t;
		t = (s >= SW'(STORE_DEPTH)) ? s - SW'(STORE_DEPTH) : s;
		return t[AW-1:0];
	endfunction

	// The padded length is worked out when a register is written, so it is
	// ready for an item that follows the write directly.
	always_comb begin
		len_wr   = (int'(cfg_data) > LEN_MAX) ? LB'(LEN_MAX) : cfg_data;
		len_nx   = (cfg_we && cfg_index == ofs_pkg::CFG_FRAME_LEN) ? len_wr : len_q;
		round_nx = (cfg_we && cfg_index == ofs_pkg::CFG_ROUND) ? cfg_data[0] : round_q;
		plen_nx  = round_nx ? ofs_pkg::ceil_pow2(len_nx) : {1'b0, len_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LB'(LEN_RST);
			hop_q   <= LB'(ofs_pkg::HOP_RST);
			round_q <= 1'b0;
			plen_q  <= PB'(LEN_RST);
		end else begin
			len_q   <= len_nx;
			round_q <= round_nx;
			plen_q  <= plen_nx;
			if (cfg_we && cfg_index == ofs_pkg::CFG_HOP) begin
				hop_q <= cfg_data;
			end
		end
	end

	always_comb begin
		head_n  = head_q;
		fill_n  = fill_q;
		pos_n   = pos_q;
		flush_n = flush_q;
		ctl_n   = '0;
		ram_we  = 1'b0;
		rpos    = '0;
		fill_x  = SW'(fill_q);
		len_x   = SW'(len_q);
		hop_x   = SW'(hop_q);
		plen_x  = SW'(plen_q);
		ready   = (len_q != '0) && (hop_q != '0) && (fill_x >= len_x + hop_x);
		drop_x  = (hop_x < fill_x) ? hop_x : fill_x;
		// A flush that starts abandons any partial frame.
		p0      = flush_q ? SW'(pos_q) : '0;
		if (accept) begin
			unique case (func)
				ofs_pkg::FUNC_PUSH: begin
					if (fill_x >= SW'(STORE_DEPTH)) begin
						ctl_n.dropped = 1'b1;
					end else begin
						ram_we = 1'b1;
						fill_n = fill_q + FILL_W'(1);
					end
				end
				ofs_pkg::FUNC_PULL: begin
					if (!flush_q && (pos_q != '0 || ready)) begin
						ctl_n.out_valid = 1'b1;
						rpos = SW'(pos_q);
						ctl_n.use_mem = (rpos < len_x) && (rpos < fill_x);
						if (rpos + SW'(1) >= plen_x) begin
							ctl_n.last = 1'b1;
							head_n = wrap(SW'(head_q) + drop_x);
							fill_n = fill_q - FILL_W'(drop_x);
							pos_n  = '0;
						end else begin
							pos_n = pos_q + POS_W'(1);
						end
					end
				end
				ofs_pkg::FUNC_FLUSH: begin
					if (flush_q || fill_q != '0) begin
						ctl_n.out_valid = 1'b1;
						ctl_n.flush = 1'b1;
						rpos = p0;
						ctl_n.use_mem = (rpos < plen_x) && (rpos < fill_x);
						if (rpos + SW'(1) >= plen_x) begin
							ctl_n.last = 1'b1;
							head_n  = '0;
							fill_n  = '0;
							pos_n   = '0;
							flush_n = 1'b0;
						end else begin
							pos_n   = POS_W'(rpos + SW'(1));
							flush_n = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		ram_re    = ctl_n.use_mem;
		ram_waddr = wrap(SW'(head_q) + fill_x);
		ram_raddr = wrap(SW'(head_q) + rpos);
		ram_wdata = sample_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
			flush_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			head_q  <= head_n;
			fill_q  <= fill_n;
			pos_q   <= pos_n;
			flush_q <= flush_n;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1      <= ctl_n;
			buffered_s1 <= fill_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ofs_outq.sv
// ----------------------------------------------------------------------------
// ofs_outq
// Output register: merges the store read data with the item's control and
// holds the result while the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofs_outq #(
	parameter int SAMPLE_BITS = 16,
	parameter int FILL_W      = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire ofs_pkg::res_ctl_t             ctl_s1,
	input  wire logic [FILL_W-1:0]             buffered_s1,
	input  wire logic [SAMPLE_BITS-1:0]        rdata,
	input  wire logic                          result_stall,
	output logic                               take_s1,
	output logic                               result_valid,
	output logic                               out_valid,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               frame_last,
	output logic                               flush_frame,
	output logic                               dropped,
	output logic [FILL_W-1:0]                  buffered
);

	assign take_s1 = valid_s1 && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take_s1) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// Positions past the fill or frame length (padded for flush) read as zeros.
	always_ff @(posedge clk) begin
		if (take_s1) begin
			out_valid   <= ctl_s1.out_valid;
			sample_out  <= ctl_s1.use_mem ? $signed(rdata) : '0;
			frame_last  <= ctl_s1.last;
			flush_frame <= ctl_s1.flush;
			dropped     <= ctl_s1.dropped;
			buffered    <= buffered_s1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/overlapped_frame_splitter_top.sv
// ----------------------------------------------------------------------------
// overlapped_frame_splitter_top
// Single-channel overlapped framer with zero padding over a ring sample store.
// ----------------------------------------------------------------------------
// Every accepted item (push, pull or flush) yields exactly one result item via
// the first stage register and the output register, and one item is accepted
// every cycle while the result side keeps up. The rate is set by the sample
// store: a push writes one entry and a pull or flush reads one entry, so each
// item uses a single port of the one-write, one-read RAM, and the read data is
// registered before the output register. Store entries are never cleared; only
// entries that were pushed are ever read, so no clearing pass runs after reset.
// Configuration writes take effect for the very next item.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module overlapped_frame_splitter_top #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_FRAME   = 512,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [1:0]                           cfg_index,
	input  wire logic [ofs_pkg::CFG_BITS-1:0]         cfg_data,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [1:0]                           func,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic                                      out_valid,
	output logic signed [SAMPLE_BITS-1:0]             sample_out,
	output logic                                      frame_last,
	output logic                                      flush_frame,
	output logic                                      dropped,
	output logic [$clog2(STORE_DEPTH+1)-1:0]          buffered
);

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int FILL_W = $clog2(STORE_DEPTH + 1);

	logic                    accept;
	logic                    valid_s1, take_s1;
	ofs_pkg::res_ctl_t       ctl_s1;
	logic [FILL_W-1:0]       buffered_s1;
	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0]  ram_wdata, ram_rdata;

	assign item_stall = valid_s1 && !take_s1;
	assign accept     = item_valid && !item_stall;

	ofs_ctrl #(
		.STORE_DEPTH(STORE_DEPTH),
		.MAX_FRAME  (MAX_FRAME),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.func       (func),
		.sample_in  ($unsigned(sample_in)),
		.take_s1    (take_s1),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.buffered_s1(buffered_s1),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr)
	);

	// One item touches at most one entry, and a write lands before the next item's
	// read, so a pull right after a push sees the new sample.
	ofs_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ofs_outq #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FILL_W     (FILL_W)
	) u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ctl_s1      (ctl_s1),
		.buffered_s1 (buffered_s1),
		.rdata       (ram_rdata),
		.result_stall(result_stall),
		.take_s1     (take_s1),
		.result_valid(result_valid),
		.out_valid   (out_valid),
		.sample_out  (sample_out),
		.frame_last  (frame_last),
		.flush_frame (flush_frame),
		.dropped     (dropped),
		.buffered    (buffered)
	);

	`OFS_ASSERT_NOW(a_s1_moves, accept && valid_s1, take_s1, "item accepted over a held stage")
	`OFS_ASSERT_NOW(a_one_port, ram_we, !ram_re, "store written and read by one item")
	`OFS_ASSERT_NEXT(a_s1_loaded, accept, valid_s1, "accepted item lost before the output")
	`OFS_ASSERT_NOW(a_drop_full, result_valid && dropped,
		buffered == FILL_W'(STORE_DEPTH), "push dropped while the store had room")
	`OFS_ASSERT_NOW(a_flush_empty, result_valid && flush_frame && frame_last,
		buffered == '0, "store not empty after the flush frame")

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the overlapped frame splitter.
// A behavioral copy of the framer inside the bench predicts every result.
// The stimulus covers directed corner cases, a full-store run, back-pressure
// on both channels, and randomized push/pull/flush traffic under changing
// frame settings.
// ---------------------------------------------------------------------------
module tb;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int DEPTH          = 1024;
	localparam int RING_AW        = $clog2(DEPTH);
	localparam int MAX_LEN        = 512;
	localparam int QUIET_LIMIT    = 4000;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int MAX_REPORTS    = 40;
	localparam int RANDOM_ITEMS   = 120;

	typedef struct packed {
		logic        out_valid;
		logic [15:0] sample;
		logic        last;
		logic        flush;
		logic        dropped;
		logic [10:0] buffered;
	} frame_result_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         cfg_we       = 1'b0;
	logic [1:0]                   cfg_index    = ofs_pkg::CFG_FRAME_LEN;
	logic [ofs_pkg::CFG_BITS-1:0] cfg_data     = '0;
	logic                         item_valid   = 1'b0;
	logic                         item_stall;
	logic [1:0]                   func         = ofs_pkg::FUNC_PUSH;
	logic signed [15:0]           sample_in    = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic                         out_valid;
	logic signed [15:0]           sample_out;
	logic                         frame_last;
	logic                         flush_frame;
	logic                         dropped;
	logic [10:0]                  buffered;

	overlapped_frame_splitter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.sample_in    (sample_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.frame_last   (frame_last),
		.flush_frame  (flush_frame),
		.dropped      (dropped),
		.buffered     (buffered)
	);

	// Framer state as the bench expects it.
	logic [15:0] ring [DEPTH];
	int ring_head  = 0;
	int ring_fill  = 0;
	int frame_idx  = 0;
	bit flushing   = 1'b0;
	int len_reg    = ofs_pkg::FRAME_LEN_RST;
	int hop_reg    = ofs_pkg::HOP_RST;
	bit round_reg  = 1'b0;

	frame_result_t pending_results[$];

	int error_count   = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int frames_done   = 0;
	int flush_frames  = 0;
	int drop_count    = 0;
	int quiet_cycles  = 0;
	bit calm          = 1'b0;
	bit hold_rx       = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int eff_frame_len();
		return (len_reg > MAX_LEN) ? MAX_LEN : len_reg;
	endfunction

	function automatic bit frame_ready();
		int len;
		len = eff_frame_len();
		return len != 0 && hop_reg != 0 && ring_fill >= len + hop_reg;
	endfunction

	// Entries past the fill level or past the limit read as zero padding.
	function automatic logic [15:0] stored_at(input int pos, input int limit);
		if (pos < limit && pos < ring_fill) begin
			return ring[RING_AW'((ring_head + pos) % DEPTH)];
		end
		return 16'h0000;
	endfunction

	function automatic frame_result_t frame_splitter_predict(input logic [1:0] f,
			input logic [15:0] s);
		frame_result_t r;
		int len, plen, d;
		r = '0;
		len = eff_frame_len();
		plen = len;
		if (round_reg) begin
			plen = 1;
			while (plen < len) plen = plen << 1;
		end
		case (f)
			ofs_pkg::FUNC_PUSH: begin
				if (ring_fill >= DEPTH) begin
					r.dropped = 1'b1;
					drop_count++;
				end else begin
					ring[RING_AW'((ring_head + ring_fill) % DEPTH)] = s;
					ring_fill++;
				end
			end
			ofs_pkg::FUNC_PULL: begin
				if (!flushing && (frame_idx != 0 || frame_ready())) begin
					r.out_valid = 1'b1;
					r.sample = stored_at(frame_idx, len);
					if (frame_idx + 1 >= plen) begin
						d = (hop_reg < ring_fill) ? hop_reg : ring_fill;
						r.last = 1'b1;
						ring_head = (ring_head + d) % DEPTH;
						ring_fill -= d;
						frame_idx = 0;
						frames_done++;
					end else begin
						frame_idx++;
					end
				end
			end
			ofs_pkg::FUNC_FLUSH: begin
				if (flushing || ring_fill != 0) begin
					// A flush abandons any partial frame and starts over at the head.
					if (!flushing) begin
						flushing = 1'b1;
						frame_idx = 0;
					end
					r.out_valid = 1'b1;
					r.flush = 1'b1;
					r.sample = stored_at(frame_idx, plen);
					if (frame_idx + 1 >= plen) begin
						r.last = 1'b1;
						ring_head = 0;
						ring_fill = 0;
						frame_idx = 0;
						flushing = 1'b0;
						flush_frames++;
					end else begin
						frame_idx++;
					end
				end
			end
			default: begin
			end
		endcase
		r.buffered = ring_fill[10:0];
		return r;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("error at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			flag_error($sformatf("result %0d %s: got %h, expected %h",
				results_seen, name, got, want));
		end
	endtask

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Command mix that follows the framer: fill, then drain whole frames, with noise.
	function automatic logic [1:0] next_command();
		int roll;
		roll = $urandom_range(0, 99);
		if (flushing) begin
			return roll < 85 ? ofs_pkg::FUNC_FLUSH : roll < 93 ? ofs_pkg::FUNC_PUSH :
				roll < 98 ? ofs_pkg::FUNC_PULL : FUNC_NONE;
		end
		if (frame_idx != 0 || frame_ready()) begin
			return roll < 70 ? ofs_pkg::FUNC_PULL : roll < 90 ? ofs_pkg::FUNC_PUSH :
				roll < 95 ? ofs_pkg::FUNC_FLUSH : FUNC_NONE;
		end
		return roll < 82 ? ofs_pkg::FUNC_PUSH : roll < 90 ? ofs_pkg::FUNC_PULL :
			roll < 96 ? ofs_pkg::FUNC_FLUSH : FUNC_NONE;
	endfunction

	// Offers one item and returns at the clock edge where it was accepted.
	task automatic send_item(input logic [1:0] f, input logic [15:0] s);
		int gap;
		bit stalled;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func <= f;
		sample_in <= s;
		do begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end while (stalled);
		pending_results.push_back(frame_splitter_predict(f, s));
		items_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		wait (pending_results.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[ofs_pkg::CFG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ofs_pkg::CFG_FRAME_LEN: len_reg = value & 'h3FF;
			ofs_pkg::CFG_HOP:       hop_reg = value & 'h3FF;
			ofs_pkg::CFG_ROUND:     round_reg = value[0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(input int len, input int hop, input int round);
		write_reg(ofs_pkg::CFG_FRAME_LEN, len);
		write_reg(ofs_pkg::CFG_HOP, hop);
		write_reg(ofs_pkg::CFG_ROUND, round);
	endtask

	task automatic test_directed_commands();
		set_frame(4, 2, 0);
		send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		send_item(FUNC_NONE, 16'h1111);
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		send_item(ofs_pkg::FUNC_PUSH, 16'h8000);
		send_item(ofs_pkg::FUNC_PUSH, 16'h7FFF);
		send_item(ofs_pkg::FUNC_PUSH, 16'h0000);
		send_item(ofs_pkg::FUNC_PUSH, 16'hFFFF);
		send_item(ofs_pkg::FUNC_PUSH, 16'h5555);
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		send_item(ofs_pkg::FUNC_PUSH, 16'hAAAA);
		repeat (5) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		send_item(ofs_pkg::FUNC_PUSH, 16'h1234);
		send_item(ofs_pkg::FUNC_PUSH, 16'h4321);
		repeat (2) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		// The flush drops the half-read frame; pulls are refused until it ends.
		send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		send_item(ofs_pkg::FUNC_PUSH, 16'h0F0F);
		repeat (3) send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		settle();
	endtask

	task automatic test_padding_and_reconfig();
		set_frame(5, 3, 1);
		repeat (8) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		repeat (8) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		repeat (3) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		repeat (2) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		settle();
		// Shrinking the frame mid-way ends it at once; the oversized hop empties the store.
		set_frame(2, 1000, 0);
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		settle();
		set_frame(2, 1, 0);
		repeat (3) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		settle();
		// Growing the frame mid-way reads past the fill level as zeros.
		write_reg(ofs_pkg::CFG_FRAME_LEN, 9);
		repeat (8) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		settle();
		set_frame(0, 1, 0);
		repeat (2) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		settle();
		set_frame(2, 0, 1);
		repeat (4) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		repeat (2) send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		settle();
	endtask

	task automatic test_store_full();
		// Frame length above the maximum saturates to a full-size frame, so the
		// full store is ready; the flush then abandons the frame that was begun.
		set_frame(1023, 512, 1);
		repeat (DEPTH + 2) send_item(ofs_pkg::FUNC_PUSH, rand_sample());
		repeat (8) send_item(ofs_pkg::FUNC_PULL, 16'h0000);
		settle();
		set_frame(3, 512, 0);
		repeat (3) send_item(ofs_pkg::FUNC_FLUSH, 16'h0000);
		settle();
	endtask

	task automatic test_backpressure();
		set_frame(3, 1, 0);
		hold_rx = 1'b1;
		calm = 1'b1;
		repeat (48) send_item(next_command(), rand_sample());
		calm = 1'b0;
		settle();
		repeat (24) send_item(next_command(), rand_sample());
		settle();
	endtask

	task automatic test_random_traffic();
		int sent, roll, nlen, nhop;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			roll = $urandom_range(0, 99);
			nlen = roll < 5 ? 0 : roll < 15 ? 1 : roll < 18 ? 1023 :
				roll < 22 ? $urandom_range(17, 40) : $urandom_range(2, 16);
			roll = $urandom_range(0, 99);
			nhop = roll < 5 ? 0 : roll < 15 ? 1 : roll < 18 ? 1023 : $urandom_range(1, 20);
			set_frame(nlen, nhop, $urandom_range(0, 1));
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(40, 120)) begin
				send_item(next_command(), rand_sample());
				sent++;
			end
			calm = 1'b0;
		end
		settle();
	endtask

	// Result side pacing: random stalls, or one long hold when a test asks for it.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				result_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Outputs are sampled at the falling edge, where they are stable until the next rise.
	always @(negedge clk) begin
		frame_result_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = {out_valid, sample_out, frame_last, flush_frame, dropped, buffered};
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result %h arrived with nothing expected", got));
			end else begin
				want = pending_results.pop_front();
				check_field("out_valid", 16'(got.out_valid), 16'(want.out_valid));
				check_field("sample_out", got.sample, want.sample);
				check_field("frame_last", 16'(got.last), 16'(want.last));
				check_field("flush_frame", 16'(got.flush), 16'(want.flush));
				check_field("dropped", 16'(got.dropped), 16'(want.dropped));
				check_field("buffered", 16'(got.buffered), 16'(want.buffered));
			end
			results_seen++;
		end
	end

	always @(negedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_commands();
		test_padding_and_reconfig();
		test_store_full();
		test_backpressure();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_results.size()));
		end
		$display("run covered %0d items and %0d results: %0d frames, %0d flush frames,",
			items_sent, results_seen, frames_done, flush_frames);
		$display("%0d dropped pushes, %0d errors", drop_count, error_count);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ofs_pkg.sv
rtl/core/ofs_ram.sv
rtl/core/ofs_ctrl.sv
rtl/core/ofs_outq.sv
rtl/core/overlapped_frame_splitter_top.sv
sim/tb.sv
